// ===== rtl/ptrn_pkg.sv =====
// Shared types and constants for the perceptron trainer.
// No dependencies; imported by ptrn_ctrl, ptrn_dpath and perceptron_trainer.
`timescale 1ns / 1ps

package ptrn_pkg;

  localparam int MAX_FEATURES_DEF = 64;
  localparam int FEAT_W           = 16;
  localparam int WEIGHT_W         = 32;
  localparam int PROD_W           = FEAT_W + WEIGHT_W;
  localparam int ACC_W            = 64;
  localparam int THR_W            = 48;
  localparam int CNT_W            = 16;
  localparam logic signed [WEIGHT_W-1:0] WEIGHT_INIT = 32'sd256;

  typedef enum logic [1:0] {
    ACT_TRAIN   = 2'd0,
    ACT_EVAL    = 2'd1,
    ACT_PREDICT = 2'd2,
    ACT_WIPE    = 2'd3
  } action_t;

  typedef struct packed {
    action_t                   action;
    logic signed [FEAT_W-1:0]  feature;
    logic                      label;
    logic                      last;
  } in_beat_t;

  typedef struct packed {
    logic             predicted;
    logic             mistake;
    logic [CNT_W-1:0] true_pos;
    logic [CNT_W-1:0] false_neg;
    logic [CNT_W-1:0] true_neg;
    logic [CNT_W-1:0] false_pos;
  } out_beat_t;

  // controller to datapath
  typedef struct packed {
    logic accept;   // non-wipe beat taken
    logic wipe;     // reset weights, counters, sample
    logic mul;      // multiply feature by its weight
    logic decide;   // classify, count, load result
    logic upd_rd;   // read one weight/feature pair for training
  } ptrn_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic idx_full;
    logic out_busy;
    logic train_miss;
    logic upd_last;
  } ptrn_sts_t;

endpackage

// ===== rtl/ptrn_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module ptrn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/ptrn_ctrl.sv =====
// Sequencing state machine for the perceptron trainer.
// Depends on ptrn_pkg for command and status structs.
`timescale 1ns / 1ps

module ptrn_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ptrn_pkg::in_beat_t  in_data,
  input  ptrn_pkg::ptrn_sts_t sts,
  output ptrn_pkg::ptrn_cmd_t cmd
);
  import ptrn_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_DECIDE,
    S_UPD,
    S_DRAIN
  } state_t;

  state_t state_r, state_nxt;
  logic   last_r, last_nxt;

  always_comb begin
    state_nxt = state_r;
    last_nxt  = last_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.action == ACT_WIPE) begin
            cmd.wipe = 1'b1;
          end else begin
            cmd.accept = 1'b1;
            last_nxt   = in_data.last;
            if (!sts.idx_full) begin
              state_nxt = S_MUL;
            end else if (in_data.last) begin
              state_nxt = S_ADD;
            end
          end
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = last_r ? S_ADD : S_IDLE;
      end
      S_ADD: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (!sts.out_busy) begin
          cmd.decide = 1'b1;
          state_nxt  = sts.train_miss ? S_UPD : S_IDLE;
        end
      end
      S_UPD: begin
        cmd.upd_rd = 1'b1;
        if (sts.upd_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

// ===== rtl/ptrn_dpath.sv =====
// Datapath: weight and sample memories, multiply-accumulate, decision,
// counters, training update and result register. Depends on ptrn_pkg, ptrn_ram.
`timescale 1ns / 1ps

module ptrn_dpath #(
  parameter int MAX_FEATURES = ptrn_pkg::MAX_FEATURES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ptrn_pkg::in_beat_t            in_data,
  input  ptrn_pkg::ptrn_cmd_t           cmd,
  output ptrn_pkg::ptrn_sts_t           sts,
  input  logic                          cfg_we,
  input  logic [ptrn_pkg::THR_W-1:0]    cfg_wdata,
  output logic                          out_valid,
  input  logic                          out_stall,
  output ptrn_pkg::out_beat_t           out_data
);
  import ptrn_pkg::*;

  localparam int AW = $clog2(MAX_FEATURES);
  localparam int IW = $clog2(MAX_FEATURES + 1);

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == {CNT_W{1'b1}}) ? c : c + CNT_W'(1);
  endfunction

  // control registers
  logic [THR_W-1:0]          thr_r;
  logic [IW-1:0]             idx_r;
  logic [IW-1:0]             upd_cnt_r;
  logic [AW-1:0]             ptr_r;
  logic [MAX_FEATURES-1:0]   wvld_r;
  logic                      wv_r;
  logic                      prod_vld_r;
  logic                      wr_pend_r;
  logic [AW-1:0]             wr_addr_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic [CNT_W-1:0]          tp_r, fn_r, tn_r, fp_r;
  logic                      out_valid_r;
  // payload registers
  logic signed [FEAT_W-1:0]  feat_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic                      label_r;
  action_t                   act_r;
  out_beat_t                 out_r;

  logic                      take;
  logic [WEIGHT_W-1:0]       w_rdata;
  logic [FEAT_W-1:0]         x_rdata;
  logic signed [WEIGHT_W-1:0] wsel;
  logic signed [FEAT_W-1:0]  xcur;
  logic signed [WEIGHT_W+1:0] wsum;
  logic signed [WEIGHT_W-1:0] wnew;
  logic                      w_re;
  logic [AW-1:0]             w_raddr;
  logic signed [ACC_W-1:0]   thr_ext;
  logic                      pred, miss;
  logic [CNT_W-1:0]          tp_nxt, fn_nxt, tn_nxt, fp_nxt;

  assign take    = cmd.accept && (idx_r != IW'(MAX_FEATURES));
  assign w_re    = take || cmd.upd_rd;
  assign w_raddr = take ? idx_r[AW-1:0] : ptr_r;

  ptrn_ram #(.WIDTH(WEIGHT_W), .DEPTH(MAX_FEATURES)) u_wram (
    .clk   (clk),
    .we    (wr_pend_r),
    .waddr (wr_addr_r),
    .wdata (wnew),
    .re    (w_re),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  ptrn_ram #(.WIDTH(FEAT_W), .DEPTH(MAX_FEATURES)) u_sbuf (
    .clk   (clk),
    .we    (take),
    .waddr (idx_r[AW-1:0]),
    .wdata (in_data.feature),
    .re    (cmd.upd_rd),
    .raddr (ptr_r),
    .rdata (x_rdata)
  );

  // never-written weights read as the reset value
  assign wsel = wv_r ? $signed(w_rdata) : WEIGHT_INIT;
  assign xcur = $signed(x_rdata);

  // weight update with 32-bit saturation
  always_comb begin
    wsum = label_r ? ({{2{wsel[WEIGHT_W-1]}}, wsel} + {{18{xcur[FEAT_W-1]}}, xcur})
                   : ({{2{wsel[WEIGHT_W-1]}}, wsel} - {{18{xcur[FEAT_W-1]}}, xcur});
    if (wsum[WEIGHT_W+1:WEIGHT_W-1] == 3'b000 || wsum[WEIGHT_W+1:WEIGHT_W-1] == 3'b111) begin
      wnew = wsum[WEIGHT_W-1:0];
    end else if (wsum[WEIGHT_W+1]) begin
      wnew = {1'b1, {(WEIGHT_W-1){1'b0}}};
    end else begin
      wnew = {1'b0, {(WEIGHT_W-1){1'b1}}};
    end
  end

  // decision and counter update
  assign thr_ext = {{(ACC_W-THR_W){thr_r[THR_W-1]}}, thr_r};
  assign pred    = acc_r > thr_ext;
  assign miss    = pred ^ label_r;

  always_comb begin
    tp_nxt = tp_r;
    fn_nxt = fn_r;
    tn_nxt = tn_r;
    fp_nxt = fp_r;
    if (act_r == ACT_EVAL) begin
      priority if (label_r && pred) begin
        tp_nxt = sat_inc(tp_r);
      end else if (label_r) begin
        fn_nxt = sat_inc(fn_r);
      end else if (!pred) begin
        tn_nxt = sat_inc(tn_r);
      end else begin
        fp_nxt = sat_inc(fp_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= '0;
      idx_r       <= '0;
      upd_cnt_r   <= '0;
      ptr_r       <= '0;
      wvld_r      <= '0;
      wv_r        <= 1'b0;
      prod_vld_r  <= 1'b0;
      wr_pend_r   <= 1'b0;
      wr_addr_r   <= '0;
      acc_r       <= '0;
      tp_r        <= '0;
      fn_r        <= '0;
      tn_r        <= '0;
      fp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      prod_vld_r <= cmd.mul;
      wr_pend_r  <= cmd.upd_rd;
      if (prod_vld_r) begin
        acc_r <= acc_r + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
      end
      if (take) begin
        wv_r  <= wvld_r[idx_r[AW-1:0]];
        idx_r <= idx_r + IW'(1);
      end
      if (cmd.upd_rd) begin
        wv_r      <= wvld_r[ptr_r];
        wr_addr_r <= ptr_r;
        ptr_r     <= ptr_r + AW'(1);
      end
      if (wr_pend_r) begin
        wvld_r[wr_addr_r] <= 1'b1;
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.decide) begin
        out_valid_r <= 1'b1;
        tp_r        <= tp_nxt;
        fn_r        <= fn_nxt;
        tn_r        <= tn_nxt;
        fp_r        <= fp_nxt;
        acc_r       <= '0;
        idx_r       <= '0;
        upd_cnt_r   <= idx_r;
        ptr_r       <= '0;
      end
      if (cmd.wipe) begin
        wvld_r <= '0;
        acc_r  <= '0;
        idx_r  <= '0;
        tp_r   <= '0;
        fn_r   <= '0;
        tn_r   <= '0;
        fp_r   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      label_r <= in_data.label;
      act_r   <= in_data.action;
    end
    if (take) begin
      feat_r <= in_data.feature;
    end
    if (cmd.mul) begin
      prod_r <= feat_r * wsel;
    end
    if (cmd.decide) begin
      out_r.predicted <= pred;
      out_r.mistake   <= miss;
      out_r.true_pos  <= tp_nxt;
      out_r.false_neg <= fn_nxt;
      out_r.true_neg  <= tn_nxt;
      out_r.false_pos <= fp_nxt;
    end
  end

  assign sts.idx_full   = (idx_r == IW'(MAX_FEATURES));
  assign sts.out_busy   = out_valid_r && out_stall;
  assign sts.train_miss = (act_r == ACT_TRAIN) && miss;
  assign sts.upd_last   = (IW'(ptr_r) == upd_cnt_r - IW'(1));

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/perceptron_trainer.sv =====
// Top level of the perceptron trainer: controller plus datapath.
// Depends on ptrn_pkg, ptrn_ctrl, ptrn_dpath (and ptrn_ram below it).
// input channel: one beat per feature, bias constant (256) first, last marks
//   the final feature; action on the last beat selects train, evaluate or
//   predict; a wipe beat restores weights to 1.0, clears counters and drops
//   the sample in progress, giving no result
// result channel: one beat per finished sample with prediction, mistake flag
//   and the four outcome counters after this sample
// config: cfg_we writes the 48-bit signed Q.16 threshold; write it only
//   while idle, the block itself does not enforce this
// steps: an ordinary feature beat is a weight read, then a multiply; the
//   add overlaps the next beat; a last beat goes on after its multiply to
//   add and compare; a training mistake adds one read-modify-write of the
//   weight memory per stored feature
// reset: synchronous rst_n; weights read as 1.0, counters and threshold zero
// stall: the result sits in an output register; the block keeps taking
//   features of the next sample and waits only when a second result is
//   ready before the first has been taken
`timescale 1ns / 1ps

module perceptron_trainer #(
  parameter int MAX_FEATURES = ptrn_pkg::MAX_FEATURES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  ptrn_pkg::in_beat_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output ptrn_pkg::out_beat_t         out_data,
  input  logic                        cfg_we,
  input  logic [ptrn_pkg::THR_W-1:0]  cfg_wdata
);
  import ptrn_pkg::*;

  // command and status between sequencer and datapath
  ptrn_cmd_t cmd;
  ptrn_sts_t sts;

  ptrn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .sts      (sts),
    .cmd      (cmd)
  );

  ptrn_dpath #(.MAX_FEATURES(MAX_FEATURES)) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
